// File: hdl/prim_mst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the minimum spanning tree weight unit.
// Used by the tree cells and the top level; depends on nothing.
package prim_mst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int IN_WEIGHT_W      = 16;
    localparam int VCOUNT_W         = 7;
    localparam int TOTAL_W          = 22;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] ACT_BEGIN   = 2'd0;
    localparam logic [1:0] ACT_EDGE    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]             action;
        logic [VCOUNT_W-1:0]    vertex_count;
        logic [VCOUNT_W-1:0]    edge_u;
        logic [VCOUNT_W-1:0]    edge_v;
        logic [IN_WEIGHT_W-1:0] edge_weight;
    } t_in_word;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_weight;
        logic               connected;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_CMP,
        ST_EDGE_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_SEED_A,
        ST_SEED_B,
        ST_WAVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic mark;
    } t_cell_cmd;

    typedef struct packed {
        logic active;
        logic valid;
    } t_tok;

endpackage

// File: hdl/prim_mst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; holds the adjacency matrix of the spanning tree unit.
module prim_mst_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/prim_mst_cell.sv
`timescale 1ns / 1ps
// One vertex cell: tree membership and best connecting weight of one vertex.
// Relaxes its weight from the broadcast row entry and passes the running minimum on.
module prim_mst_cell #(
    parameter int VW    = 6,
    parameter int WB    = 16,
    parameter int INDEX = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  prim_mst_pkg::t_cell_cmd i_cmd,
    input  logic [VW-1:0]          i_mark_idx,
    input  logic                   i_ent_valid,
    input  logic [WB-1:0]          i_ent_w,
    input  prim_mst_pkg::t_tok     i_tok,
    input  logic [WB-1:0]          i_tok_w,
    input  logic [VW-1:0]          i_tok_idx,
    output prim_mst_pkg::t_tok     o_tok,
    output logic [WB-1:0]          o_tok_w,
    output logic [VW-1:0]          o_tok_idx
);

    logic               r_in;
    logic               r_bv;
    logic [WB-1:0]      r_bw;
    prim_mst_pkg::t_tok r_tok;
    logic [WB-1:0]      r_tw;
    logic [VW-1:0]      r_ti;

    logic          relax;
    logic          nb_v;
    logic [WB-1:0] nb_w;
    logic          cand;

    always_comb begin
        relax = i_ent_valid && !r_in && (!r_bv || (i_ent_w < r_bw));
        nb_v  = r_bv || relax;
        nb_w  = relax ? i_ent_w : r_bw;
        cand  = !r_in && nb_v && (!i_tok.valid || (nb_w < i_tok_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in  <= 1'b0;
            r_bv  <= 1'b0;
            r_tok <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_in <= 1'b0;
                r_bv <= 1'b0;
            end else if (i_cmd.mark && (i_mark_idx == VW'(INDEX))) begin
                r_in <= 1'b1;
                r_bv <= 1'b0;
            end else if (i_tok.active) begin
                r_bv <= nb_v;
            end
            r_tok.active <= i_tok.active;
            r_tok.valid  <= i_tok.active && (cand || i_tok.valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.active) begin
            r_bw <= nb_w;
            r_tw <= cand ? nb_w : i_tok_w;
            r_ti <= cand ? VW'(INDEX) : i_tok_idx;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_w   = r_tw;
    assign o_tok_idx = r_ti;

endmodule

// File: hdl/prim_mst_weight_unit.sv
`timescale 1ns / 1ps
// A begin word and reset clear all 2**(2*clog2(MAX_VERTICES)) matrix entries (4096).
// An edge word writes its weight to (u,v) and (v,u) when that entry is empty or heavier;
// an invalid edge word is ignored. A compute word scans all vertex pairs for the lightest edge,
// then joins one vertex per pass down the cell row, and stops early with fewer than two vertices.
// Throughput is one word at a time; busy stays high until the word is finished.
// Reset is synchronous and active low; the result strobe lasts one cycle and cannot be stalled.
module prim_mst_weight_unit #(
    parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = prim_mst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  prim_mst_pkg::t_in_word  i_item,
    output logic                    o_strobe,
    output prim_mst_pkg::t_out_word o_result
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = WEIGHT_BITS + 1;
    localparam int SW    = WEIGHT_BITS + CW;

    prim_mst_pkg::t_state r_state, n_state;

    logic [CW-1:0]          r_n;
    logic [VW-1:0]          r_ui, r_vi;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [AW-1:0]          r_clr;
    logic [VW-1:0]          r_a, r_b, r_pa, r_pb;
    logic                   r_sv;
    logic                   r_found;
    logic [WEIGHT_BITS-1:0] r_sw;
    logic [VW-1:0]          r_sa, r_sb;
    logic [SW-1:0]          r_sum;
    logic [CW-1:0]          r_cnt;
    logic [VW-1:0]          r_src, r_j;
    logic                   r_issue, r_inj, r_first;

    logic                   accept;
    logic [WEIGHT_BITS-1:0] w_in;
    logic [CW-1:0]          n_sat;
    logic                   edge_ok;
    logic                   scan_last;
    logic                   upd;
    logic                   rd_valid;
    logic [WEIGHT_BITS-1:0] rd_w;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    prim_mst_pkg::t_cell_cmd cmd;
    logic [VW-1:0]           mark_idx;

    prim_mst_pkg::t_tok     tok     [0:MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] tok_w   [0:MAX_VERTICES];
    logic [VW-1:0]          tok_idx [0:MAX_VERTICES];

    logic last_act, last_val, pick;

    generate
        if (WEIGHT_BITS <= prim_mst_pkg::IN_WEIGHT_W) begin : g_wtrunc
            assign w_in = i_item.edge_weight[WEIGHT_BITS-1:0];
        end else begin : g_wext
            assign w_in = WEIGHT_BITS'(i_item.edge_weight);
        end
    endgenerate

    always_comb begin
        accept    = start && !busy;
        n_sat     = (32'(i_item.vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                              : CW'(i_item.vertex_count);
        edge_ok   = (i_item.edge_u != '0) && (i_item.edge_v != '0)
                 && (32'(i_item.edge_u) <= 32'(r_n)) && (32'(i_item.edge_v) <= 32'(r_n))
                 && (i_item.edge_u != i_item.edge_v);
        scan_last = (CW'(r_a) == r_n - CW'(2)) && (CW'(r_b) == r_n - CW'(1));
        rd_valid  = mem_rdata[EW-1];
        rd_w      = mem_rdata[WEIGHT_BITS-1:0];
        upd       = !rd_valid || (r_w < rd_w);
        last_act  = tok[MAX_VERTICES].active;
        last_val  = tok[MAX_VERTICES].valid;
        pick      = (r_state == prim_mst_pkg::ST_WAVE) && last_act && !r_first && last_val;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prim_mst_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.action)
                        prim_mst_pkg::ACT_BEGIN:   n_state = prim_mst_pkg::ST_CLEAR;
                        prim_mst_pkg::ACT_EDGE:    n_state = edge_ok ? prim_mst_pkg::ST_EDGE_RD
                                                                     : prim_mst_pkg::ST_IDLE;
                        prim_mst_pkg::ACT_COMPUTE: n_state = (r_n >= CW'(2))
                                                             ? prim_mst_pkg::ST_SCAN
                                                             : prim_mst_pkg::ST_DONE;
                        default:                   n_state = prim_mst_pkg::ST_IDLE;
                    endcase
                end
            end
            prim_mst_pkg::ST_CLEAR: begin
                if (r_clr == {AW{1'b1}}) n_state = prim_mst_pkg::ST_IDLE;
            end
            prim_mst_pkg::ST_EDGE_RD:  n_state = prim_mst_pkg::ST_EDGE_CMP;
            prim_mst_pkg::ST_EDGE_CMP: n_state = upd ? prim_mst_pkg::ST_EDGE_WR
                                                     : prim_mst_pkg::ST_IDLE;
            prim_mst_pkg::ST_EDGE_WR:  n_state = prim_mst_pkg::ST_IDLE;
            prim_mst_pkg::ST_SCAN: begin
                if (scan_last) n_state = prim_mst_pkg::ST_SCAN_END;
            end
            prim_mst_pkg::ST_SCAN_END: n_state = prim_mst_pkg::ST_SEED_A;
            prim_mst_pkg::ST_SEED_A:   n_state = r_found ? prim_mst_pkg::ST_SEED_B
                                                         : prim_mst_pkg::ST_DONE;
            prim_mst_pkg::ST_SEED_B:   n_state = prim_mst_pkg::ST_WAVE;
            prim_mst_pkg::ST_WAVE: begin
                if (last_act && !r_first && !last_val) n_state = prim_mst_pkg::ST_DONE;
            end
            prim_mst_pkg::ST_DONE:     n_state = prim_mst_pkg::ST_IDLE;
            default:                   n_state = prim_mst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_ui, r_vi};
        mem_wdata = {1'b1, r_w};
        mem_raddr = {r_src, r_j};
        cmd       = '0;
        mark_idx  = r_sa;
        o_strobe  = 1'b0;
        busy      = 1'b1;
        unique case (r_state)
            prim_mst_pkg::ST_IDLE: begin
                busy      = 1'b0;
                cmd.clear = accept && (i_item.action == prim_mst_pkg::ACT_COMPUTE);
            end
            prim_mst_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            prim_mst_pkg::ST_EDGE_RD: begin
                mem_raddr = {r_ui, r_vi};
            end
            prim_mst_pkg::ST_EDGE_CMP: begin
                mem_we = upd;
            end
            prim_mst_pkg::ST_EDGE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_vi, r_ui};
            end
            prim_mst_pkg::ST_SCAN: begin
                mem_raddr = {r_a, r_b};
            end
            prim_mst_pkg::ST_SCAN_END: begin
            end
            prim_mst_pkg::ST_SEED_A: begin
                cmd.mark = r_found;
                mark_idx = r_sa;
            end
            prim_mst_pkg::ST_SEED_B: begin
                cmd.mark = 1'b1;
                mark_idx = r_sb;
            end
            prim_mst_pkg::ST_WAVE: begin
                cmd.mark = pick;
                mark_idx = tok_idx[MAX_VERTICES];
            end
            prim_mst_pkg::ST_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
            end
        endcase
        o_result.total_weight = (64'(r_sum) > 64'(prim_mst_pkg::TOTAL_MAX))
                                ? prim_mst_pkg::TOTAL_MAX
                                : prim_mst_pkg::TOTAL_W'(r_sum);
        o_result.connected    = (r_n <= CW'(1)) || (r_found && (r_cnt == r_n));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prim_mst_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_n     <= '0;
            r_sv    <= 1'b0;
            r_found <= 1'b0;
            r_issue <= 1'b0;
            r_inj   <= 1'b0;
            r_first <= 1'b0;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == prim_mst_pkg::ST_SCAN);
            r_inj   <= (r_state == prim_mst_pkg::ST_WAVE) && r_issue && (r_j == '0);
            if (r_state == prim_mst_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept && (i_item.action == prim_mst_pkg::ACT_BEGIN)) begin
                r_n   <= n_sat;
                r_clr <= '0;
            end
            if (accept && (i_item.action == prim_mst_pkg::ACT_COMPUTE)) begin
                r_found <= 1'b0;
                r_sum   <= '0;
                r_cnt   <= '0;
            end
            if (r_sv && rd_valid && (!r_found || (rd_w < r_sw))) begin
                r_found <= 1'b1;
            end
            if ((r_state == prim_mst_pkg::ST_SEED_A) && r_found) begin
                r_sum <= SW'(r_sw);
                r_cnt <= CW'(2);
            end
            if (r_state == prim_mst_pkg::ST_SEED_B) begin
                r_first <= 1'b1;
                r_issue <= 1'b1;
            end
            if ((r_state == prim_mst_pkg::ST_WAVE) && r_issue
                && (r_j == VW'(MAX_VERTICES - 1))) begin
                r_issue <= 1'b0;
            end
            if ((r_state == prim_mst_pkg::ST_WAVE) && last_act && (r_first || last_val)) begin
                r_first <= 1'b0;
                r_issue <= 1'b1;
            end
            if (pick) begin
                r_sum <= r_sum + SW'(tok_w[MAX_VERTICES]);
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.action == prim_mst_pkg::ACT_EDGE)) begin
            r_ui <= VW'(32'(i_item.edge_u) - 1);
            r_vi <= VW'(32'(i_item.edge_v) - 1);
            r_w  <= w_in;
        end
        if (accept && (i_item.action == prim_mst_pkg::ACT_COMPUTE)) begin
            r_a <= '0;
            r_b <= VW'(1);
        end
        if (r_state == prim_mst_pkg::ST_SCAN) begin
            r_pa <= r_a;
            r_pb <= r_b;
            if (CW'(r_b) == r_n - CW'(1)) begin
                r_a <= r_a + VW'(1);
                r_b <= r_a + VW'(2);
            end else begin
                r_b <= r_b + VW'(1);
            end
        end
        if (r_sv && rd_valid && (!r_found || (rd_w < r_sw))) begin
            r_sw <= rd_w;
            r_sa <= r_pa;
            r_sb <= r_pb;
        end
        if (r_state == prim_mst_pkg::ST_SEED_B) begin
            r_src <= r_sa;
            r_j   <= '0;
        end else if ((r_state == prim_mst_pkg::ST_WAVE) && last_act) begin
            r_src <= r_first ? r_sb : tok_idx[MAX_VERTICES];
            r_j   <= '0;
        end else if ((r_state == prim_mst_pkg::ST_WAVE) && r_issue) begin
            r_j <= r_j + VW'(1);
        end
    end

    prim_mst_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign tok[0].active = r_inj;
    assign tok[0].valid  = 1'b0;
    assign tok_w[0]      = '0;
    assign tok_idx[0]    = '0;

    generate
        for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
            prim_mst_cell #(
                .VW    (VW),
                .WB    (WEIGHT_BITS),
                .INDEX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_mark_idx  (mark_idx),
                .i_ent_valid (rd_valid),
                .i_ent_w     (rd_w),
                .i_tok       (tok[g]),
                .i_tok_w     (tok_w[g]),
                .i_tok_idx   (tok_idx[g]),
                .o_tok       (tok[g+1]),
                .o_tok_w     (tok_w[g+1]),
                .o_tok_idx   (tok_idx[g+1])
            );
        end
    endgenerate

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.action == prim_mst_pkg::ACT_COMPUTE)) |=> busy)
        else $error("compute word did not raise busy");

    a_wave_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == prim_mst_pkg::ST_WAVE) && last_act) |-> !r_issue)
        else $error("pass left the cell row before all row reads were issued");
`endif

endmodule
